// ===== sv/jadz_pkg.sv =====
// ----------------------------------------------------------------------------
// jadz_pkg
// Shared types and constants for the joystick axis deadzone scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jadz_pkg;

  // default width of raw axis positions and limits
  localparam int unsigned AXIS_BITS_DEF = 16;

  // fixed port widths
  localparam int unsigned RAW_BITS = 16;
  localparam int unsigned BTN_BITS = 24;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // hat decode
  localparam int unsigned POV_STEP = 9000;
  localparam logic [RAW_BITS-1:0] POV_CENTRED = 16'hFFFF;
  localparam int unsigned HAT_STEPS = 7;
  localparam int unsigned HAT_IDX_BITS = $clog2(HAT_STEPS + 1);

  // axis result codes
  localparam logic [RAW_BITS-1:0] FAIL_VALUE = 16'd32000;
  localparam logic [RAW_BITS-1:0] SAT_POS = 16'h007F;
  localparam logic [RAW_BITS-1:0] SAT_NEG = 16'hFF80;

  // divider lane: one quotient bit per stage plus magnitude and overflow stages
  localparam int unsigned QUO_BITS = 8;
  localparam int unsigned LANE_STAGES = QUO_BITS + 2;

  // queue depths
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ENABLED = 3'd0,
    CFG_HAS_POV = 3'd1,
    CFG_X_LO    = 3'd2,
    CFG_X_HI    = 3'd3,
    CFG_Y_LO    = 3'd4,
    CFG_Y_HI    = 3'd5,
    CFG_Z_LO    = 3'd6,
    CFG_Z_HI    = 3'd7
  } cfg_idx_e;

  // how a reading is handled
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_FAIL = 2'd1,
    MODE_RUN  = 2'd2
  } mode_e;

  // global flags from the register file
  typedef struct packed {
    logic enabled;
    logic has_pov;
  } cfg_flags_t;

  // one result word
  typedef struct packed {
    logic [RAW_BITS-1:0] axis_z;
    logic [RAW_BITS-1:0] axis_y;
    logic [RAW_BITS-1:0] axis_x;
    logic [BTN_BITS-1:0] buttons;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/jadz_fifo.sv =====
// ----------------------------------------------------------------------------
// jadz_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jadz_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  // no write into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i && full_o))
    else $error("queue written while full");

  // no read from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop_i && empty_o))
    else $error("queue read while empty");

  // a write alone raises the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level lost a word");

endmodule

`default_nettype wire

// ===== sv/jadz_front.sv =====
// ----------------------------------------------------------------------------
// jadz_front
// Accepts readings, decodes the hat, classifies each axis (dead zone, range)
// and forms the scaled numerator for the divider lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jadz_front #(
  parameter int unsigned AxisBits = jadz_pkg::AXIS_BITS_DEF
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  // register file view
  input  wire jadz_pkg::cfg_flags_t                      flags_i,
  input  wire logic [2:0][AxisBits+1:0]                  k_i,
  input  wire logic [2:0][AxisBits+5:0]                  c20_i,
  input  wire logic [2:0][AxisBits-1:0]                  rng_i,
  input  wire logic [2:0]                                rpos_i,
  // reading side
  input  wire logic                                      push_i,
  output logic                                           full_o,
  input  wire logic                                      read_ok_i,
  input  wire logic [2:0][jadz_pkg::RAW_BITS-1:0]        pos_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]             buttons_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]             angle_i,
  // classified word to the back part
  output logic                                           item_push_o,
  input  wire logic                                      item_full_i,
  output jadz_pkg::mode_e                                item_mode_o,
  output logic [jadz_pkg::BTN_BITS-1:0]                  item_buttons_o,
  output logic [2:0]                                     item_zero_o,
  output logic [2:0][AxisBits+9:0]                       item_num_o
);

  localparam int unsigned AB = AxisBits;

  logic adv;
  logic accept;

  // stage 0: captured reading
  logic                              v0_q;
  logic                              ok0_q;
  logic [2:0][AB-1:0]                pos0_q;
  logic [jadz_pkg::RAW_BITS-1:0]     btn0_q;
  logic [jadz_pkg::RAW_BITS-1:0]     ang0_q;

  // stage 1: mode, buttons, 20 * position
  logic                              v1_q;
  jadz_pkg::mode_e                   mode1_q, mode1_d;
  logic [jadz_pkg::BTN_BITS-1:0]     btn1_q, btn1_d;
  logic [2:0][AB-1:0]                pos1_q;
  logic [2:0][AB+4:0]                p20_1_q, p20_1_d;

  // stage 2: offset from centre and numerator base
  logic                              v2_q;
  jadz_pkg::mode_e                   mode2_q;
  logic [jadz_pkg::BTN_BITS-1:0]     btn2_q;
  logic [2:0][AB+6:0]                e2_q, e2_d;
  logic [2:0][AB+1:0]                n2_q, n2_d;

  logic [jadz_pkg::HAT_IDX_BITS-1:0] hat_idx;
  logic                              hat_on;
  logic [jadz_pkg::BTN_BITS-1:0]     btn_all;

  // whole front moves together; holds while stage 2 has a word and the mid queue is full
  assign adv         = !(v2_q && item_full_i);
  assign full_o      = !adv;
  assign accept      = push_i && adv;
  assign item_push_o = v2_q && !item_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // stage 0 capture
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok0_q  <= read_ok_i;
      btn0_q <= buttons_i;
      ang0_q <= angle_i;
      for (int a = 0; a < 3; a++) begin
        pos0_q[a] <= pos_i[a][AB-1:0];
      end
    end
  end

  // hat sector, mode and button word
  always_comb begin
    hat_idx = '0;
    for (int i = 1; i <= jadz_pkg::HAT_STEPS; i++) begin
      hat_idx = hat_idx
              + jadz_pkg::HAT_IDX_BITS'(ang0_q >= jadz_pkg::RAW_BITS'(i * jadz_pkg::POV_STEP));
    end
    hat_on  = flags_i.has_pov && (ang0_q != jadz_pkg::POV_CENTRED);
    btn_all = {{(jadz_pkg::BTN_BITS - jadz_pkg::RAW_BITS){1'b0}}, btn0_q};
    if (hat_on) begin
      btn_all = btn_all | (jadz_pkg::BTN_BITS'(1) << (jadz_pkg::RAW_BITS + 32'(hat_idx)));
    end
    priority if (!flags_i.enabled) begin
      mode1_d = jadz_pkg::MODE_OFF;
    end else if (!ok0_q) begin
      mode1_d = jadz_pkg::MODE_FAIL;
    end else begin
      mode1_d = jadz_pkg::MODE_RUN;
    end
    btn1_d = (mode1_d == jadz_pkg::MODE_RUN) ? btn_all : '0;
    for (int a = 0; a < 3; a++) begin
      p20_1_d[a] = ((AB+5)'(pos0_q[a]) << 4) + ((AB+5)'(pos0_q[a]) << 2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q <= mode1_d;
      btn1_q  <= btn1_d;
      pos1_q  <= pos0_q;
      p20_1_q <= p20_1_d;
    end
  end

  // offset of 20 * position from 20 * centre, and pos - hi + half
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      e2_d[a] = $unsigned($signed({2'b00, p20_1_q[a]}) - $signed({1'b0, c20_i[a]}));
      n2_d[a] = $unsigned($signed({2'b00, pos1_q[a]}) + $signed(k_i[a]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode2_q <= mode1_q;
      btn2_q  <= btn1_q;
      e2_q    <= e2_d;
      n2_q    <= n2_d;
    end
  end

  // dead zone: |pos - centre| <= range / 20 is the same as 20 * |pos - centre| <= range
  always_comb begin
    logic signed [AB+6:0] rng_s;
    logic                 dz;
    logic [AB+9:0]        n_ext;
    for (int a = 0; a < 3; a++) begin
      rng_s          = $signed({7'b0000000, rng_i[a]});
      dz             = ($signed(e2_q[a]) <= rng_s) && ($signed(e2_q[a]) >= -rng_s);
      item_zero_o[a] = !rpos_i[a] || dz;
      n_ext          = {{8{n2_q[a][AB+1]}}, n2_q[a]};
      item_num_o[a]  = (n_ext << 8) - n_ext;
    end
  end

  assign item_mode_o    = mode2_q;
  assign item_buttons_o = btn2_q;

endmodule

`default_nettype wire

// ===== sv/jadz_div.sv =====
// ----------------------------------------------------------------------------
// jadz_div
// Pipelined restoring divider for one axis: magnitude of the numerator over
// the axis range, one quotient bit per stage, with an overflow flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jadz_div #(
  parameter int unsigned AxisBits = jadz_pkg::AXIS_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          adv_i,
  input  wire logic [AxisBits+9:0]           num_i,
  input  wire logic [AxisBits-1:0]           rng_i,
  output logic                               neg_o,
  output logic                               ovf_o,
  output logic [jadz_pkg::QUO_BITS-1:0]      quo_o
);

  localparam int unsigned NumW = AxisBits + 10;
  localparam int unsigned MagW = AxisBits + 9;
  localparam int unsigned RemW = AxisBits + 8;
  localparam int unsigned QB   = jadz_pkg::QUO_BITS;
  localparam int unsigned L    = jadz_pkg::LANE_STAGES;

  logic [NumW-1:0] abs_num;
  logic [MagW-1:0] mag_q;
  logic            neg_q [L];
  logic            ovf_q [1:L-1];
  logic [RemW-1:0] rem_q [1:L-1];
  logic [QB-1:0]   quo_q [1:L-1];

  // stage 0: sign and magnitude
  assign abs_num = num_i[NumW-1] ? (~num_i + 1'b1) : num_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg_q[0] <= num_i[NumW-1];
      mag_q    <= abs_num[MagW-1:0];
    end
  end

  // stage 1: quotient of 256 or more saturates either way
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      neg_q[1] <= neg_q[0];
      ovf_q[1] <= (mag_q >= {1'b0, rng_i, {QB{1'b0}}});
      rem_q[1] <= mag_q[RemW-1:0];
      quo_q[1] <= '0;
    end
  end

  // quotient bit stages, msb first
  for (genvar j = 2; j < L; j++) begin : g_bit
    localparam int unsigned B = L - 1 - j;
    logic [RemW-1:0] trial;
    assign trial = RemW'(rng_i) << B;
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        neg_q[j] <= neg_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        if (rem_q[j-1] >= trial) begin
          rem_q[j] <= rem_q[j-1] - trial;
          quo_q[j] <= quo_q[j-1] | (QB'(1) << B);
        end else begin
          rem_q[j] <= rem_q[j-1];
          quo_q[j] <= quo_q[j-1];
        end
      end
    end
  end

  assign neg_o = neg_q[L-1];
  assign ovf_o = ovf_q[L-1];
  assign quo_o = quo_q[L-1];

endmodule

`default_nettype wire

// ===== sv/jadz_back.sv =====
// ----------------------------------------------------------------------------
// jadz_back
// Takes classified words from the mid queue, runs the three divider lanes,
// saturates and assembles the result word for the output queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jadz_back #(
  parameter int unsigned AxisBits = jadz_pkg::AXIS_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [2:0][AxisBits-1:0]          rng_i,
  // mid queue side
  input  wire logic                              item_valid_i,
  output logic                                   item_pop_o,
  input  wire jadz_pkg::mode_e                   item_mode_i,
  input  wire logic [jadz_pkg::BTN_BITS-1:0]     item_buttons_i,
  input  wire logic [2:0]                        item_zero_i,
  input  wire logic [2:0][AxisBits+9:0]          item_num_i,
  // output queue side
  output logic                                   out_push_o,
  input  wire logic                              out_full_i,
  output jadz_pkg::res_t                         out_word_o
);

  localparam int unsigned L  = jadz_pkg::LANE_STAGES;
  localparam int unsigned QB = jadz_pkg::QUO_BITS;

  logic adv;

  logic [L-1:0]                  vld_q;
  jadz_pkg::mode_e               mode_q [L];
  logic [jadz_pkg::BTN_BITS-1:0] btn_q  [L];
  logic [2:0]                    zero_q [L];

  logic [2:0]                    neg;
  logic [2:0]                    ovf;
  logic [2:0][QB-1:0]            quo;

  logic                          vf_q;
  logic [2:0][jadz_pkg::RAW_BITS-1:0] ax_q, ax_d;
  logic [jadz_pkg::BTN_BITS-1:0] fbtn_q;

  // back moves together; holds while a result waits and the output queue is full
  assign adv        = !(vf_q && out_full_i);
  assign item_pop_o = item_valid_i && adv;
  assign out_push_o = vf_q && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vf_q  <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[L-2:0], item_pop_o};
      vf_q  <= vld_q[L-1];
    end
  end

  // side data delayed alongside the lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode_q[0] <= item_mode_i;
      btn_q[0]  <= item_buttons_i;
      zero_q[0] <= item_zero_i;
      for (int j = 1; j < L; j++) begin
        mode_q[j] <= mode_q[j-1];
        btn_q[j]  <= btn_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
  end

  // one divider lane per axis
  for (genvar a = 0; a < 3; a++) begin : g_lane
    jadz_div #(
      .AxisBits (AxisBits)
    ) u_div (
      .clk_i (clk_i),
      .adv_i (adv),
      .num_i (item_num_i[a]),
      .rng_i (rng_i[a]),
      .neg_o (neg[a]),
      .ovf_o (ovf[a]),
      .quo_o (quo[a])
    );
  end

  // saturate to -128..127 and apply reading mode
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (mode_q[L-1])
        jadz_pkg::MODE_OFF: begin
          ax_d[a] = '0;
        end
        jadz_pkg::MODE_FAIL: begin
          ax_d[a] = jadz_pkg::FAIL_VALUE;
        end
        jadz_pkg::MODE_RUN: begin
          if (zero_q[L-1][a]) begin
            ax_d[a] = '0;
          end else if (neg[a]) begin
            ax_d[a] = (ovf[a] || quo[a] > QB'(128)) ? jadz_pkg::SAT_NEG
                    : jadz_pkg::RAW_BITS'(0) - jadz_pkg::RAW_BITS'(quo[a]);
          end else begin
            ax_d[a] = (ovf[a] || quo[a] > QB'(127)) ? jadz_pkg::SAT_POS
                    : jadz_pkg::RAW_BITS'(quo[a]);
          end
        end
        default: begin
          ax_d[a] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q   <= ax_d;
      fbtn_q <= btn_q[L-1];
    end
  end

  assign out_word_o.axis_x  = ax_q[0];
  assign out_word_o.axis_y  = ax_q[1];
  assign out_word_o.axis_z  = ax_q[2];
  assign out_word_o.buttons = fbtn_q;

endmodule

`default_nettype wire

// ===== sv/joystick_axis_deadzone_scaler.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_deadzone_scaler
// Scales three joystick axes with a dead zone and merges hat and buttons.
// ----------------------------------------------------------------------------
// Takes one reading per clock while full is low and gives one result word per
// reading, in order; a reading passes the front stages, the mid queue, the
// divider lanes, the result register and the output queue before it shows on
// the output ports (empty low). The per-axis restoring divider resolves one
// quotient bit per pipeline stage. Limits must be written through the config
// port only while no reading is in flight; the block does not enforce this.
// They take effect once the range and then the derived limits are re-registered.
// A failed read gives 32000 on every axis, a disabled block gives all zeros.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_deadzone_scaler #(
  parameter int unsigned AxisBits = jadz_pkg::AXIS_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // config write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [jadz_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [jadz_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // readings
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic                                 read_ok_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]        raw_x_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]        raw_y_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]        raw_z_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]        raw_buttons_i,
  input  wire logic [jadz_pkg::RAW_BITS-1:0]        pov_angle_i,
  // results
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [jadz_pkg::RAW_BITS-1:0]      axis_x_o,
  output logic signed [jadz_pkg::RAW_BITS-1:0]      axis_y_o,
  output logic signed [jadz_pkg::RAW_BITS-1:0]      axis_z_o,
  output logic [jadz_pkg::BTN_BITS-1:0]             button_bits_o
);

  localparam int unsigned AB      = AxisBits;
  localparam int unsigned MidW    = 2 + jadz_pkg::BTN_BITS + 3 + 3 * (AB + 10);
  localparam int unsigned NumAllW = 3 * (AB + 10);

  // reset values of the derived limits for lo = 0, hi = all ones
  localparam logic [AB-1:0]   AxOnes    = '1;
  localparam logic [AB-2:0]   RstHalf   = AxOnes[AB-1:1];
  localparam logic [AB+1:0]   RstK      = {3'b000, RstHalf} - {2'b00, AxOnes};
  localparam logic [AB:0]     RstCentre = {2'b00, RstHalf};
  localparam logic [AB+5:0]   RstC20    = ((AB+6)'(RstCentre) << 4)
                                        + ((AB+6)'(RstCentre) << 2);

  // register file
  logic                 enabled_q;
  logic                 has_pov_q;
  logic [2:0][AB-1:0]   lo_q;
  logic [2:0][AB-1:0]   hi_q;

  // derived limits
  logic [2:0][AB:0]     rng1_q, rng1_d;
  logic [2:0][AB-1:0]   rng_q, rng_d;
  logic [2:0]           rpos_q, rpos_d;
  logic [2:0][AB+1:0]   k_q, k_d;
  logic [2:0][AB+5:0]   c20_q, c20_d;

  jadz_pkg::cfg_flags_t flags;

  // front to mid queue
  logic                          f_push;
  logic                          mid_full;
  jadz_pkg::mode_e               f_mode;
  logic [jadz_pkg::BTN_BITS-1:0] f_btn;
  logic [2:0]                    f_zero;
  logic [2:0][AB+9:0]            f_num;
  logic [MidW-1:0]               mid_wdata;
  logic [MidW-1:0]               mid_rdata;
  logic                          mid_empty;
  logic                          b_pop;

  // back to output queue
  logic                          b_push;
  logic                          out_full;
  jadz_pkg::res_t                b_word;
  jadz_pkg::res_t                out_word;
  logic                          out_empty;

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      has_pov_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (jadz_pkg::cfg_idx_e'(cfg_index_i))
        jadz_pkg::CFG_ENABLED: enabled_q <= cfg_data_i[0];
        jadz_pkg::CFG_HAS_POV: has_pov_q <= cfg_data_i[0];
        jadz_pkg::CFG_X_LO:    lo_q[0]   <= cfg_data_i[AB-1:0];
        jadz_pkg::CFG_X_HI:    hi_q[0]   <= cfg_data_i[AB-1:0];
        jadz_pkg::CFG_Y_LO:    lo_q[1]   <= cfg_data_i[AB-1:0];
        jadz_pkg::CFG_Y_HI:    hi_q[1]   <= cfg_data_i[AB-1:0];
        jadz_pkg::CFG_Z_LO:    lo_q[2]   <= cfg_data_i[AB-1:0];
        jadz_pkg::CFG_Z_HI:    hi_q[2]   <= cfg_data_i[AB-1:0];
        default: begin
        end
      endcase
    end
  end

  // range, then half, centre and offsets
  always_comb begin
    logic [AB-2:0] half;
    logic [AB:0]   centre;
    for (int a = 0; a < 3; a++) begin
      rng1_d[a] = {1'b0, hi_q[a]} - {1'b0, lo_q[a]};
      half      = rng1_q[a][AB-1:1];
      centre    = {1'b0, lo_q[a]} + {2'b00, half};
      rng_d[a]  = rng1_q[a][AB-1:0];
      rpos_d[a] = !rng1_q[a][AB] && (rng1_q[a] != '0);
      k_d[a]    = {3'b000, half} - {2'b00, hi_q[a]};
      c20_d[a]  = ((AB+6)'(centre) << 4) + ((AB+6)'(centre) << 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        rng1_q[a] <= {1'b0, AxOnes};
        rng_q[a]  <= AxOnes;
        rpos_q[a] <= 1'b1;
        k_q[a]    <= RstK;
        c20_q[a]  <= RstC20;
      end
    end else begin
      rng1_q <= rng1_d;
      rng_q  <= rng_d;
      rpos_q <= rpos_d;
      k_q    <= k_d;
      c20_q  <= c20_d;
    end
  end

  assign flags.enabled = enabled_q;
  assign flags.has_pov = has_pov_q;

  // front: accept and classify
  jadz_front #(
    .AxisBits (AxisBits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .flags_i        (flags),
    .k_i            (k_q),
    .c20_i          (c20_q),
    .rng_i          (rng_q),
    .rpos_i         (rpos_q),
    .push_i         (push),
    .full_o         (full),
    .read_ok_i      (read_ok_i),
    .pos_i          ({raw_z_i, raw_y_i, raw_x_i}),
    .buttons_i      (raw_buttons_i),
    .angle_i        (pov_angle_i),
    .item_push_o    (f_push),
    .item_full_i    (mid_full),
    .item_mode_o    (f_mode),
    .item_buttons_o (f_btn),
    .item_zero_o    (f_zero),
    .item_num_o     (f_num)
  );

  // mid queue between front and back
  assign mid_wdata = {f_mode, f_btn, f_zero, f_num};

  jadz_fifo #(
    .Width (MidW),
    .Depth (jadz_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (b_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  // back: divide, saturate, assemble
  jadz_back #(
    .AxisBits (AxisBits)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rng_i          (rng_q),
    .item_valid_i   (!mid_empty),
    .item_pop_o     (b_pop),
    .item_mode_i    (jadz_pkg::mode_e'(mid_rdata[MidW-1 -: 2])),
    .item_buttons_i (mid_rdata[MidW-3 -: jadz_pkg::BTN_BITS]),
    .item_zero_i    (mid_rdata[NumAllW+2 -: 3]),
    .item_num_i     (mid_rdata[NumAllW-1:0]),
    .out_push_o     (b_push),
    .out_full_i     (out_full),
    .out_word_o     (b_word)
  );

  // output queue
  jadz_fifo #(
    .Width ($bits(jadz_pkg::res_t)),
    .Depth (jadz_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_push),
    .data_i  (b_word),
    .full_o  (out_full),
    .pop_i   (pop && !out_empty),
    .data_o  (out_word),
    .empty_o (out_empty)
  );

  assign empty         = out_empty;
  assign axis_x_o      = $signed(out_word.axis_x);
  assign axis_y_o      = $signed(out_word.axis_y);
  assign axis_z_o      = $signed(out_word.axis_z);
  assign button_bits_o = out_word.buttons;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joystick axis deadzone scaler.
// A clocked driver pushes joystick readings in bursts from a queue that the
// stimulus process fills. Each accepted reading is scored on the spot against
// a local copy of the limits and flags. A clocked monitor pops result words
// under a changing stall pattern and compares every field with the oldest
// predicted word. Limits change only between phases, once all words are back.
// ----------------------------------------------------------------------------
module testbench;
  import jadz_pkg::*;

  localparam int unsigned CLK_HALF       = 10;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned PIPE_LATENCY   = 15;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_READINGS = 130;
  localparam int unsigned MAX_PRINTS     = 40;

  // one joystick reading as pushed
  typedef struct packed {
    logic                ok;
    logic [RAW_BITS-1:0] x;
    logic [RAW_BITS-1:0] y;
    logic [RAW_BITS-1:0] z;
    logic [RAW_BITS-1:0] btn;
    logic [RAW_BITS-1:0] angle;
  } reading_t;

  // one scaled result word
  typedef struct packed {
    logic [RAW_BITS-1:0] ax;
    logic [RAW_BITS-1:0] ay;
    logic [RAW_BITS-1:0] az;
    logic [BTN_BITS-1:0] btn;
  } scaled_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i    = '0;
  logic                      push          = 1'b0;
  logic                      full;
  logic                      read_ok_i     = 1'b0;
  logic [RAW_BITS-1:0]       raw_x_i       = '0;
  logic [RAW_BITS-1:0]       raw_y_i       = '0;
  logic [RAW_BITS-1:0]       raw_z_i       = '0;
  logic [RAW_BITS-1:0]       raw_buttons_i = '0;
  logic [RAW_BITS-1:0]       pov_angle_i   = '0;
  logic                      empty;
  logic                      pop           = 1'b0;
  logic signed [RAW_BITS-1:0] axis_x_o;
  logic signed [RAW_BITS-1:0] axis_y_o;
  logic signed [RAW_BITS-1:0] axis_z_o;
  logic [BTN_BITS-1:0]       button_bits_o;

  // local copy of the register file
  logic                cfg_en  = 1'b0;
  logic                cfg_pov = 1'b0;
  logic [RAW_BITS-1:0] lim_lo [3];
  logic [RAW_BITS-1:0] lim_hi [3];

  reading_t pending_q [$];
  scaled_t  scaled_q [$];
  reading_t cur_rd;
  scaled_t  got_want;
  int       queued_total   = 0;
  int       accepted_total = 0;
  int       words_seen     = 0;
  int       settings_count = 0;
  int       mismatches     = 0;
  int       burst_left     = 1;
  int       gap_left       = 0;
  int unsigned clk_count   = 0;

  joystick_axis_deadzone_scaler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .read_ok_i     (read_ok_i),
    .raw_x_i       (raw_x_i),
    .raw_y_i       (raw_y_i),
    .raw_z_i       (raw_z_i),
    .raw_buttons_i (raw_buttons_i),
    .pov_angle_i   (pov_angle_i),
    .empty         (empty),
    .pop           (pop),
    .axis_x_o      (axis_x_o),
    .axis_y_o      (axis_y_o),
    .axis_z_o      (axis_z_o),
    .button_bits_o (button_bits_o)
  );

  // clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // one line per mismatch, printing capped
  task automatic flag_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", clk_count, what, got, want);
    end
  endtask

  // axis scaling with dead zone, signed truncating divide, saturation
  function automatic logic [RAW_BITS-1:0] deadzone_axis(logic [RAW_BITS-1:0] pos,
                                                        logic [RAW_BITS-1:0] lo,
                                                        logic [RAW_BITS-1:0] hi);
    int p, l, h, span, half, mid, dz, offs, q;
    p = int'(pos);
    l = int'(lo);
    h = int'(hi);
    span = h - l;
    if (span <= 0) return '0;
    half = span / 2;
    mid = l + half;
    dz = span / 20;
    offs = p - mid;
    if (offs < 0) offs = -offs;
    if (offs <= dz) return '0;
    q = (255 * (p - h + half)) / span;
    if (q > 127) q = 127;
    if (q < -128) q = -128;
    return q[RAW_BITS-1:0];
  endfunction

  // expected word for one reading under the current settings
  function automatic scaled_t scale_reading(reading_t r);
    scaled_t w;
    w = '0;
    if (cfg_en) begin
      if (r.ok) begin
        w.ax = deadzone_axis(r.x, lim_lo[0], lim_hi[0]);
        w.ay = deadzone_axis(r.y, lim_lo[1], lim_hi[1]);
        w.az = deadzone_axis(r.z, lim_lo[2], lim_hi[2]);
        w.btn = {8'h00, r.btn};
        if (cfg_pov && r.angle != POV_CENTRED) begin
          w.btn = w.btn | (24'h010000 << (r.angle / POV_STEP));
        end
      end else begin
        w.ax = FAIL_VALUE;
        w.ay = FAIL_VALUE;
        w.az = FAIL_VALUE;
      end
    end
    return w;
  endfunction

  // register write over the config channel
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_ENABLED: cfg_en = val[0];
      CFG_HAS_POV: cfg_pov = val[0];
      CFG_X_LO:    lim_lo[0] = val;
      CFG_X_HI:    lim_hi[0] = val;
      CFG_Y_LO:    lim_lo[1] = val;
      CFG_Y_HI:    lim_hi[1] = val;
      CFG_Z_LO:    lim_lo[2] = val;
      default:     lim_hi[2] = val;
    endcase
  endtask

  task automatic program_regs(logic en, logic pov,
                              logic [15:0] xl, logic [15:0] xh,
                              logic [15:0] yl, logic [15:0] yh,
                              logic [15:0] zl, logic [15:0] zh);
    write_reg(CFG_X_LO, xl);
    write_reg(CFG_X_HI, xh);
    write_reg(CFG_Y_LO, yl);
    write_reg(CFG_Y_HI, yh);
    write_reg(CFG_Z_LO, zl);
    write_reg(CFG_Z_HI, zh);
    write_reg(CFG_HAS_POV, {15'd0, pov});
    write_reg(CFG_ENABLED, {15'd0, en});
    settings_count++;
  endtask

  task automatic queue_reading(logic ok, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                               logic [15:0] btn, logic [15:0] angle);
    reading_t r;
    r = '{ok: ok, x: x, y: y, z: z, btn: btn, angle: angle};
    pending_q.push_back(r);
    queued_total++;
  endtask

  // wait until every queued reading is accepted and every word is back
  task automatic drain();
    do @(negedge clk_i); while (accepted_total != queued_total || scaled_q.size() != 0);
  endtask

  // positions aimed at the limits, the dead zone edge and beyond
  function automatic logic [15:0] pick_pos(logic [15:0] lo, logic [15:0] hi);
    int l, h, span, mid, dz, p;
    l = int'(lo);
    h = int'(hi);
    span = (h > l) ? h - l : l - h;
    mid = (l + h) / 2;
    dz = span / 20;
    case ($urandom_range(0, 5))
      0: p = $urandom_range(0, 65535);
      1: p = ($urandom_range(0, 1) != 0) ? 0 : 65535;
      2: begin
        if ($urandom_range(0, 1) != 0) p = mid + dz + int'($urandom_range(0, 2)) - 1;
        else p = mid - dz - int'($urandom_range(0, 2)) + 1;
      end
      3: p = (($urandom_range(0, 1) != 0) ? l : h) + int'($urandom_range(0, 8)) - 4;
      default: p = $urandom_range(lo, hi);
    endcase
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return p[15:0];
  endfunction

  function automatic logic [15:0] pick_angle();
    int a;
    case ($urandom_range(0, 3))
      0: a = 65535;
      1: a = $urandom_range(0, 35999);
      2: a = $urandom_range(0, 65535);
      default: a = 9000 * int'($urandom_range(0, 7)) + int'($urandom_range(0, 1)) - 1;
    endcase
    if (a < 0) a = 0;
    return a[15:0];
  endfunction

  task automatic pick_limits(output logic [15:0] lo, output logic [15:0] hi);
    logic [15:0] a, b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(0, 6))
      0: begin lo = 16'h0000; hi = 16'hFFFF; end
      1: begin lo = a; hi = a; end
      2: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end
      3: begin
        lo = 16'($urandom_range(0, 65495));
        hi = lo + 16'($urandom_range(1, 40));
      end
      4: begin
        case ($urandom_range(0, 2))
          0: begin lo = 16'hFFFF; hi = 16'h0000; end
          1: begin lo = 16'hFFFF; hi = 16'hFFFF; end
          default: begin lo = 16'h0000; hi = 16'h0001; end
        endcase
      end
      default: begin lo = (a > b) ? b : a; hi = (a > b) ? a : b; end
    endcase
  endtask

  task automatic random_phase(int n);
    logic [15:0] xl, xh, yl, yh, zl, zh;
    logic        ok;
    pick_limits(xl, xh);
    pick_limits(yl, yh);
    pick_limits(zl, zh);
    program_regs($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                 xl, xh, yl, yh, zl, zh);
    for (int i = 0; i < n; i++) begin
      ok = ($urandom_range(0, 7) != 0);
      queue_reading(ok, pick_pos(lim_lo[0], lim_hi[0]), pick_pos(lim_lo[1], lim_hi[1]),
                    pick_pos(lim_lo[2], lim_hi[2]), 16'($urandom), pick_angle());
    end
    drain();
  endtask

  // stimulus
  initial begin
    lim_lo = '{16'h0000, 16'h0000, 16'h0000};
    lim_hi = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: block disabled, every field must be zero
    queue_reading(1'b1, 16'hFFFF, 16'h0000, 16'h1234, 16'hFFFF, 16'h0000);
    queue_reading(1'b0, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h4650);
    drain();

    // full range with hat: axis ends, dead zone edges, hat sectors, failed reads
    program_regs(1'b1, 1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
    queue_reading(1'b1, 16'd0, 16'd65535, 16'd32767, 16'hFFFF, 16'd0);
    queue_reading(1'b1, 16'd36043, 16'd36044, 16'd29491, 16'h0000, 16'd8999);
    queue_reading(1'b1, 16'd29490, 16'd1, 16'd65534, 16'hA5A5, 16'd9000);
    queue_reading(1'b1, 16'd32768, 16'd32766, 16'd40000, 16'h5A5A, 16'd35999);
    queue_reading(1'b1, 16'd10, 16'd60000, 16'd20000, 16'h0001, 16'd36000);
    queue_reading(1'b1, 16'd65535, 16'd0, 16'd12345, 16'h8000, 16'd65534);
    queue_reading(1'b1, 16'd50000, 16'd15000, 16'd32767, 16'h00FF, 16'd65535);
    queue_reading(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    queue_reading(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd65535);
    queue_reading(1'b1, 16'd1000, 16'd64000, 16'd33000, 16'hFF00, 16'd18000);
    queue_reading(1'b1, 16'd3000, 16'd62000, 16'd30000, 16'h0F0F, 16'd27000);
    drain();

    // narrow x beyond its limits, zero y range, inverted z range, hat off
    program_regs(1'b1, 1'b0, 16'd1000, 16'd1010, 16'd500, 16'd500, 16'd600, 16'd100);
    queue_reading(1'b1, 16'd0, 16'd500, 16'd300, 16'h1111, 16'd0);
    queue_reading(1'b1, 16'd65535, 16'd0, 16'd65535, 16'h2222, 16'd9000);
    queue_reading(1'b1, 16'd1005, 16'd65535, 16'd0, 16'h4444, 16'd36000);
    queue_reading(1'b1, 16'd1011, 16'd501, 16'd600, 16'h8888, 16'd65534);
    drain();

    // limits at the extremes of their range
    program_regs(1'b1, 1'b1, 16'h0000, 16'h0001, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000);
    queue_reading(1'b1, 16'd1, 16'd65535, 16'd65535, 16'h0000, 16'd26999);
    queue_reading(1'b1, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd17999);
    drain();

    // random settings, random readings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_phase(PHASE_READINGS);
    end

    repeat (PIPE_LATENCY * 3) @(posedge clk_i);
    if (scaled_q.size() != 0) flag_mismatch("words never produced", 0, scaled_q.size());
    $display("covered %0d readings under %0d register settings, %0d words compared",
             accepted_total, settings_count, words_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // reading driver: bursts of pushes separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push          <= 1'b0;
      read_ok_i     <= 1'b0;
      raw_x_i       <= '0;
      raw_y_i       <= '0;
      raw_z_i       <= '0;
      raw_buttons_i <= '0;
      pov_angle_i   <= '0;
    end else begin
      // score the word taken at this edge
      if (push && !full) begin
        scaled_q.push_back(scale_reading(cur_rd));
        accepted_total++;
      end
      // line is free: idle or present the next reading
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_rd = pending_q.pop_front();
          read_ok_i     <= cur_rd.ok;
          raw_x_i       <= cur_rd.x;
          raw_y_i       <= cur_rd.y;
          raw_z_i       <= cur_rd.z;
          raw_buttons_i <= cur_rd.btn;
          pov_angle_i   <= cur_rd.angle;
          push          <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor and pop stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        words_seen++;
        if (scaled_q.size() == 0) begin
          flag_mismatch("word with nothing expected, axis_x", axis_x_o, 0);
        end else begin
          got_want = scaled_q.pop_front();
          if (axis_x_o !== got_want.ax) flag_mismatch("axis_x", axis_x_o, $signed(got_want.ax));
          if (axis_y_o !== got_want.ay) flag_mismatch("axis_y", axis_y_o, $signed(got_want.ay));
          if (axis_z_o !== got_want.az) flag_mismatch("axis_z", axis_z_o, $signed(got_want.az));
          if (button_bits_o !== got_want.btn) begin
            flag_mismatch("button_bits", button_bits_o, got_want.btn);
          end
        end
      end
      // stall mode rotates: none, coin flip, mostly stalled, a regular pattern tied to the cycle counter
      case ((clk_count / 97) % 4)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom_range(0, 1));
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (clk_count % 3 == 0);
      endcase
    end
  end

  // run limit
  always @(posedge clk_i) begin
    clk_count <= clk_count + 1;
    if (clk_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", clk_count, scaled_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
sv/jadz_pkg.sv
sv/jadz_fifo.sv
sv/jadz_front.sv
sv/jadz_div.sv
sv/jadz_back.sv
sv/joystick_axis_deadzone_scaler.sv
test/testbench.sv
